// ===== hdl/mmeu_pkg.sv =====
// Package: opcodes, function codes and controller/datapath command types.
package mmeu_pkg;

    localparam logic [2:0] OP_RTYPE = 3'd0;
    localparam logic [2:0] OP_J     = 3'd1;
    localparam logic [2:0] OP_BNE   = 3'd2;
    localparam logic [2:0] OP_BEQ   = 3'd3;
    localparam logic [2:0] OP_LW    = 3'd4;
    localparam logic [2:0] OP_SW    = 3'd5;

    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_SUB  = 3'd1;
    localparam logic [2:0] FN_MULT = 3'd2;
    localparam logic [2:0] FN_DIV  = 3'd3;

    localparam int MD_STEPS = 32;

    typedef struct packed {
        logic capture;
        logic read_regs;
        logic md_start;
        logic md_step;
        logic finish;
        logic commit;
    } mmeu_cmd_t;

    typedef struct packed {
        logic needs_md;
        logic clr_busy;
        logic md_last;
    } mmeu_status_t;

endpackage

// ===== hdl/mmeu_ctrl.sv =====
// Controller: sequences operand read, iterative multiply/divide and result hand-off.
module mmeu_ctrl
    import mmeu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         out_stall,
    output logic         out_valid,
    input  mmeu_status_t status,
    output mmeu_cmd_t    cmd
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MEM, S_MD, S_EXEC, S_OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE) || status.clr_busy;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !status.clr_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_regs = 1'b1;
                state_next    = S_MEM;
            end
            S_MEM:
            begin
                if (status.needs_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_MD;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_MD:
            begin
                cmd.md_step = 1'b1;
                if (status.md_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg != S_OUT && out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/mmeu_dp.sv =====
// Datapath: pc, register file, data memory and shared iterative multiply/divide unit.
module mmeu_dp
    import mmeu_pkg::*;
#(
    parameter int REG_COUNT  = 32,
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mmeu_cmd_t          cmd,
    output mmeu_status_t       status,
    input  logic               instr_present,
    input  logic [2:0]         req_type,
    input  logic [2:0]         func_code,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_reg_a,
    input  logic [4:0]         src_reg_b,
    input  logic [7:0]         immediate,
    output logic [7:0]         next_pc,
    output logic               wr_a_en,
    output logic [4:0]         wr_a_index,
    output logic signed [31:0] wr_a_value,
    output logic               wr_b_en,
    output logic signed [31:0] wr_b_value,
    output logic               mem_wr_en,
    output logic [7:0]         mem_addr,
    output logic signed [31:0] mem_value,
    output logic               div_by_zero
);

    localparam int RW = $clog2(REG_COUNT);
    localparam int DW = $clog2(DATA_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH);
    localparam int CW = $clog2(MD_STEPS + 1);
    localparam logic [RW-1:0] QUOT_REG = RW'(24);
    localparam logic [RW-1:0] REM_REG  = RW'(25);

    // modulo of an 8-bit value by a constant, shift-compare-subtract
    function automatic logic [31:0] mod_small(logic [7:0] v, int m);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--)
        begin
            if (r >= 32'(m << k))
                r = r - 32'(m << k);
        end
        return r;
    endfunction

    logic [31:0] regs_reg [REG_COUNT];
    logic [REG_COUNT-1:0] rvalid_reg;
    logic [31:0] dmem_reg [DATA_DEPTH];
    logic [DW:0] clr_reg;

    logic          pres_reg;
    logic [2:0]    op_reg, fn_reg;
    logic [4:0]    rd_reg_q, ra_reg, rb_reg;
    logic [7:0]    imm_reg;
    logic [PW-1:0] pc_reg;
    logic [31:0]   a_reg, b_reg, s_reg, mrd_reg;

    logic [31:0] acc_reg, quo_reg, mul_reg;
    logic [CW-1:0] cnt_reg;
    logic        na_reg, nb_reg;

    logic [PW-1:0] pc_new_reg;
    logic          wa_en_reg, wb_en_reg, m_en_reg, dz_reg;
    logic [4:0]    wa_idx_reg;
    logic [31:0]   wa_val_reg, wb_val_reg, m_val_reg;
    logic [7:0]    m_addr_reg;

    logic [PW-1:0] pc_new_next;
    logic          wa_en_next, wb_en_next, m_en_next, dz_next;
    logic [4:0]    wa_idx_next;
    logic [31:0]   wa_val_next, wb_val_next, m_val_next;
    logic [7:0]    m_addr_next;

    logic [7:0]    nxt_pc_reg;
    logic          o_wa_en_reg, o_wb_en_reg, o_m_en_reg, o_dz_reg;
    logic [4:0]    o_wa_idx_reg;
    logic [31:0]   o_wa_val_reg, o_wb_val_reg, o_m_val_reg;
    logic [7:0]    o_m_addr_reg;

    logic [RW-1:0] ia, ib, idr, widx;
    logic [DW-1:0] daddr;
    logic [31:0]   ua, ub;
    logic [32:0]   trial;
    logic [31:0]   shifted;
    logic [PW-1:0] pc_adv, target;
    logic          is_div, is_mul;

    assign ia    = RW'(mod_small({3'd0, ra_reg}, REG_COUNT));
    assign ib    = RW'(mod_small({3'd0, rb_reg}, REG_COUNT));
    assign idr   = RW'(mod_small({3'd0, rd_reg_q}, REG_COUNT));
    assign widx  = RW'(mod_small({3'd0, wa_idx_reg}, REG_COUNT));
    assign daddr = DW'(mod_small(imm_reg, DATA_DEPTH));
    assign target = PW'(mod_small(imm_reg, PROG_DEPTH));
    assign pc_adv = (32'(pc_reg) + 32'd1 >= 32'(PROG_DEPTH)) ? '0 : pc_reg + 1'b1;
    assign is_mul = pres_reg && op_reg == OP_RTYPE && fn_reg == FN_MULT;
    assign is_div = pres_reg && op_reg == OP_RTYPE && fn_reg == FN_DIV && b_reg != 32'd0;
    assign ua = a_reg[31] ? 32'(0 - a_reg) : a_reg;
    assign ub = b_reg[31] ? 32'(0 - b_reg) : b_reg;
    assign shifted = {acc_reg[30:0], quo_reg[31]};
    assign trial = {1'b0, shifted} - {1'b0, b_reg};

    assign status.needs_md  = is_mul || is_div;
    assign status.clr_busy  = (clr_reg < (DW+1)'(DATA_DEPTH));
    assign status.md_last   = (cnt_reg == CW'(1));

    always_comb
    begin
        pc_new_next = pc_adv;
        wa_en_next  = 1'b0;
        wa_idx_next = 5'd0;
        wa_val_next = 32'd0;
        wb_en_next  = 1'b0;
        wb_val_next = 32'd0;
        m_en_next   = 1'b0;
        m_addr_next = 8'd0;
        m_val_next  = 32'd0;
        dz_next     = 1'b0;
        if (pres_reg)
        begin
            case (op_reg)
                OP_RTYPE:
                begin
                    case (fn_reg)
                        FN_ADD, FN_SUB:
                        begin
                            wa_en_next  = 1'b1;
                            wa_idx_next = rd_reg_q;
                            wa_val_next = (fn_reg == FN_ADD) ? a_reg + b_reg
                                                             : a_reg - b_reg;
                        end
                        FN_MULT:
                        begin
                            wa_en_next  = 1'b1;
                            wa_idx_next = 5'(QUOT_REG);
                            wa_val_next = acc_reg;
                        end
                        FN_DIV:
                        begin
                            if (!is_div)
                                dz_next = 1'b1;
                            else
                            begin
                                wa_en_next  = 1'b1;
                                wa_idx_next = 5'(QUOT_REG);
                                wa_val_next = (na_reg != nb_reg) ? 32'(0 - quo_reg)
                                                                 : quo_reg;
                                wb_en_next  = 1'b1;
                                wb_val_next = na_reg ? 32'(0 - acc_reg) : acc_reg;
                            end
                        end
                        default:
                            wa_en_next = 1'b0;
                    endcase
                end
                OP_J:
                    pc_new_next = target;
                OP_BNE, OP_BEQ:
                    if ((a_reg == b_reg) == (op_reg == OP_BEQ))
                        pc_new_next = target;
                OP_LW:
                begin
                    wa_en_next  = 1'b1;
                    wa_idx_next = rd_reg_q;
                    wa_val_next = mrd_reg;
                end
                OP_SW:
                begin
                    m_en_next   = 1'b1;
                    m_addr_next = 8'(daddr);
                    m_val_next  = s_reg;
                end
                default:
                    pc_new_next = pc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pres_reg <= instr_present;
            op_reg   <= req_type;
            fn_reg   <= func_code;
            rd_reg_q <= dest_reg;
            ra_reg   <= src_reg_a;
            rb_reg   <= src_reg_b;
            imm_reg  <= immediate;
        end
        if (cmd.read_regs)
        begin
            a_reg   <= rvalid_reg[ia] ? regs_reg[ia] : 32'd0;
            b_reg   <= rvalid_reg[ib] ? regs_reg[ib] : 32'd0;
            s_reg   <= rvalid_reg[idr] ? regs_reg[idr] : 32'd0;
            mrd_reg <= dmem_reg[daddr];
        end
        if (cmd.md_start)
        begin
            na_reg  <= a_reg[31];
            nb_reg  <= b_reg[31];
            cnt_reg <= CW'(MD_STEPS);
            acc_reg <= 32'd0;
            if (is_mul)
            begin
                quo_reg <= a_reg;
                mul_reg <= b_reg;
            end
            else
            begin
                quo_reg <= ua;
                b_reg   <= ub;
            end
        end
        else if (cmd.md_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (is_mul)
            begin
                quo_reg <= quo_reg >> 1;
                if (quo_reg[0])
                    acc_reg <= acc_reg + mul_reg;
                mul_reg <= mul_reg << 1;
            end
            else if (!trial[32])
            begin
                acc_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                acc_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            pc_new_reg <= pc_new_next;
            wa_en_reg  <= wa_en_next;
            wa_idx_reg <= wa_idx_next;
            wa_val_reg <= wa_val_next;
            wb_en_reg  <= wb_en_next;
            wb_val_reg <= wb_val_next;
            m_en_reg   <= m_en_next;
            m_addr_reg <= m_addr_next;
            m_val_reg  <= m_val_next;
            dz_reg     <= dz_next;
        end
        if (cmd.commit)
        begin
            nxt_pc_reg   <= 8'(pc_new_reg);
            o_wa_en_reg  <= wa_en_reg;
            o_wa_idx_reg <= wa_idx_reg;
            o_wa_val_reg <= wa_val_reg;
            o_wb_en_reg  <= wb_en_reg;
            o_wb_val_reg <= wb_val_reg;
            o_m_en_reg   <= m_en_reg;
            o_m_addr_reg <= m_addr_reg;
            o_m_val_reg  <= m_val_reg;
            o_dz_reg     <= dz_reg;
            if (wa_en_reg)
                regs_reg[widx] <= wa_val_reg;
            if (wb_en_reg)
                regs_reg[REM_REG] <= wb_val_reg;
        end
        if (cmd.commit && m_en_reg)
            dmem_reg[DW'(m_addr_reg)] <= m_val_reg;
        else if (clr_reg < (DW+1)'(DATA_DEPTH))
            dmem_reg[clr_reg[DW-1:0]] <= 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            rvalid_reg <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            if (clr_reg < (DW+1)'(DATA_DEPTH) && !(cmd.commit && m_en_reg))
                clr_reg <= clr_reg + 1'b1;
            if (cmd.commit)
            begin
                pc_reg <= pc_new_reg;
                if (wa_en_reg)
                    rvalid_reg[widx] <= 1'b1;
                if (wb_en_reg)
                    rvalid_reg[REM_REG] <= 1'b1;
            end
        end
    end

    assign next_pc     = nxt_pc_reg;
    assign wr_a_en     = o_wa_en_reg;
    assign wr_a_index  = o_wa_idx_reg;
    assign wr_a_value  = o_wa_val_reg;
    assign wr_b_en     = o_wb_en_reg;
    assign wr_b_value  = o_wb_val_reg;
    assign mem_wr_en   = o_m_en_reg;
    assign mem_addr    = o_m_addr_reg;
    assign mem_value   = o_m_val_reg;
    assign div_by_zero = o_dz_reg;

endmodule

// ===== hdl/mini_mips_execute_unit_core.sv =====
// Top level: small MIPS-subset execute unit, controller plus datapath.
// Usage:
//  - Input channel (in_valid/in_stall) carries one decoded instruction per
//    transaction, or an empty slot (instr_present low).
//  - Output channel (out_valid/out_stall) carries one result transaction per
//    instruction: next pc and the register and memory writes performed.
//  - MULT and DIV (non-zero divisor) run 32 steps of the shared
//    shift-add/shift-subtract unit; other instructions bypass it.
//  - One instruction is in flight at a time; in_stall is high until its result
//    has been loaded into the output register.
//  - The output register holds a result while out_stall is high; the next
//    instruction may be taken and worked on meanwhile, and waits in its
//    result step until the output register frees.
//  - Reset clears pc and register-file valid bits at once; the data memory is
//    swept to zero after reset, one entry per cycle, and
//    in_stall stays high until the sweep is done.
module mini_mips_execute_unit_core
    import mmeu_pkg::*;
#(
    parameter int REG_COUNT  = 32,
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               instr_present,
    input  logic [2:0]         req_type,
    input  logic [2:0]         func_code,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_reg_a,
    input  logic [4:0]         src_reg_b,
    input  logic [7:0]         immediate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         next_pc,
    output logic               wr_a_en,
    output logic [4:0]         wr_a_index,
    output logic signed [31:0] wr_a_value,
    output logic               wr_b_en,
    output logic signed [31:0] wr_b_value,
    output logic               mem_wr_en,
    output logic [7:0]         mem_addr,
    output logic signed [31:0] mem_value,
    output logic               div_by_zero
);

    mmeu_cmd_t    cmd;
    mmeu_status_t status;

    mmeu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    mmeu_dp #(
        .REG_COUNT  (REG_COUNT),
        .DATA_DEPTH (DATA_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .instr_present (instr_present),
        .req_type      (req_type),
        .func_code     (func_code),
        .dest_reg      (dest_reg),
        .src_reg_a     (src_reg_a),
        .src_reg_b     (src_reg_b),
        .immediate     (immediate),
        .next_pc       (next_pc),
        .wr_a_en       (wr_a_en),
        .wr_a_index    (wr_a_index),
        .wr_a_value    (wr_a_value),
        .wr_b_en       (wr_b_en),
        .wr_b_value    (wr_b_value),
        .mem_wr_en     (mem_wr_en),
        .mem_addr      (mem_addr),
        .mem_value     (mem_value),
        .div_by_zero   (div_by_zero)
    );

endmodule

// ===== bench/tb_mini_mips_execute_unit_core.sv =====
// Testbench for mini_mips_execute_unit_core: random and directed instruction stream vs. predictor.
module tb_mini_mips_execute_unit_core;
    import mmeu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       present;
        logic [2:0] op;
        logic [2:0] fn;
        logic [4:0] rd;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [7:0] imm;
    } instr_t;

    typedef struct packed {
        logic [7:0]  pc;
        logic        a_en;
        logic [4:0]  a_idx;
        logic [31:0] a_val;
        logic        b_en;
        logic [31:0] b_val;
        logic        m_en;
        logic [7:0]  m_addr;
        logic [31:0] m_val;
        logic        dz;
    } effect_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic instr_present;
    logic [2:0] req_type, func_code;
    logic [4:0] dest_reg, src_reg_a, src_reg_b;
    logic [7:0] immediate, next_pc, mem_addr;
    logic wr_a_en, wr_b_en, mem_wr_en, div_by_zero;
    logic [4:0] wr_a_index;
    logic signed [31:0] wr_a_value, wr_b_value, mem_value;

    mini_mips_execute_unit_core dut (.*);

    instr_t  pending_instrs[$];
    effect_t expected_effects[$];
    logic [7:0]  pc_model;
    logic [31:0] regs_model[32];
    logic [31:0] dmem_model[256];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 0;
    bit stim_done = 0;
    int n_txn = 0, n_div = 0, n_dz = 0, n_mem = 0;

    function automatic logic [7:0] pc_inc(logic [7:0] p);
        return p + 8'd1;
    endfunction

    function automatic effect_t execute_instr(instr_t t);
        effect_t e;
        logic [31:0] a, b, ua, ub, q, r;
        logic na, nb;
        e = '0;
        a = regs_model[t.ra];
        b = regs_model[t.rb];
        if (!t.present)
            pc_model = pc_inc(pc_model);
        else if (t.op == OP_RTYPE)
        begin
            if (t.fn == FN_ADD || t.fn == FN_SUB)
            begin
                e.a_en = 1;
                e.a_idx = t.rd;
                e.a_val = (t.fn == FN_ADD) ? a + b : a - b;
            end
            else if (t.fn == FN_MULT)
            begin
                e.a_en = 1;
                e.a_idx = 5'd24;
                e.a_val = a * b;
            end
            else if (t.fn == FN_DIV)
            begin
                if (b == 0)
                    e.dz = 1;
                else
                begin
                    na = a[31];
                    nb = b[31];
                    ua = na ? -a : a;
                    ub = nb ? -b : b;
                    q = ua / ub;
                    r = ua % ub;
                    if (na != nb) q = -q;
                    if (na) r = -r;
                    e.a_en = 1;
                    e.a_idx = 5'd24;
                    e.a_val = q;
                    e.b_en = 1;
                    e.b_val = r;
                end
            end
            pc_model = pc_inc(pc_model);
        end
        else if (t.op == OP_J)
            pc_model = t.imm;
        else if (t.op == OP_BNE || t.op == OP_BEQ)
        begin
            if ((t.op == OP_BNE) ? (a != b) : (a == b))
                pc_model = t.imm;
            else
                pc_model = pc_inc(pc_model);
        end
        else if (t.op == OP_LW)
        begin
            e.a_en = 1;
            e.a_idx = t.rd;
            e.a_val = dmem_model[t.imm];
            pc_model = pc_inc(pc_model);
        end
        else if (t.op == OP_SW)
        begin
            e.m_en = 1;
            e.m_addr = t.imm;
            e.m_val = regs_model[t.rd];
            pc_model = pc_inc(pc_model);
        end
        if (e.a_en) regs_model[e.a_idx] = e.a_val;
        if (e.b_en) regs_model[25] = e.b_val;
        if (e.m_en) dmem_model[e.m_addr] = e.m_val;
        e.pc = pc_model;
        return e;
    endfunction

    function automatic instr_t mk(logic [2:0] op, logic [2:0] fn, logic [4:0] rd,
                                 logic [4:0] ra, logic [4:0] rb, logic [7:0] imm);
        instr_t t;
        t = '{1'b1, op, fn, rd, ra, rb, imm};
        return t;
    endfunction

    function automatic instr_t rand_instr();
        instr_t t;
        int k;
        t = instr_t'({$urandom, $urandom});
        t.present = ($urandom_range(0, 19) != 0);
        k = $urandom_range(0, 99);
        if (k < 45) t.op = OP_RTYPE;
        else if (k < 60) t.op = OP_LW;
        else if (k < 80) t.op = OP_SW;
        else if (k < 97) t.op = 3'($urandom_range(1, 3));
        else t.op = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) < 8) t.fn = 3'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) t.imm = 8'($urandom_range(0, 7));
        return t;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("mini_mips_execute_unit_core: mismatch");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            {instr_present, req_type, func_code, dest_reg, src_reg_a, src_reg_b, immediate} <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                expected_effects.push_back(execute_instr(
                    {instr_present, req_type, func_code, dest_reg, src_reg_a, src_reg_b,
                     immediate}));
            end
            if (pending_instrs.size() > 0 && !hold_send
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1;
                {instr_present, req_type, func_code, dest_reg, src_reg_a, src_reg_b,
                 immediate} <= pending_instrs.pop_front();
            end
            else
                in_valid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        effect_t e;
        if (!rst_n)
            out_stall <= 1;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_txn++;
                if (expected_effects.size() == 0)
                begin
                    $error("unexpected transaction, next_pc %0d", next_pc);
                    errors++;
                end
                else
                begin
                    e = expected_effects.pop_front();
                    if (e.dz) n_dz++;
                    if (e.b_en) n_div++;
                    if (e.m_en) n_mem++;
                    if (next_pc !== e.pc)
                    begin $error("next_pc exp %0d got %0d", e.pc, next_pc); errors++; end
                    if (wr_a_en !== e.a_en)
                    begin $error("wr_a_en exp %0d got %0d", e.a_en, wr_a_en); errors++; end
                    if (wr_a_index !== e.a_idx)
                    begin $error("wr_a_index exp %0d got %0d", e.a_idx, wr_a_index); errors++; end
                    if (wr_a_value !== e.a_val)
                    begin $error("wr_a_value exp %0h got %0h", e.a_val, wr_a_value); errors++; end
                    if (wr_b_en !== e.b_en)
                    begin $error("wr_b_en exp %0d got %0d", e.b_en, wr_b_en); errors++; end
                    if (wr_b_value !== e.b_val)
                    begin $error("wr_b_value exp %0h got %0h", e.b_val, wr_b_value); errors++; end
                    if (mem_wr_en !== e.m_en)
                    begin $error("mem_wr_en exp %0d got %0d", e.m_en, mem_wr_en); errors++; end
                    if (mem_addr !== e.m_addr)
                    begin $error("mem_addr exp %0d got %0d", e.m_addr, mem_addr); errors++; end
                    if (mem_value !== e.m_val)
                    begin $error("mem_value exp %0h got %0h", e.m_val, mem_value); errors++; end
                    if (div_by_zero !== e.dz)
                    begin $error("div_by_zero exp %0d got %0d", e.dz, div_by_zero); errors++; end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic drain();
        while (pending_instrs.size() > 0 || in_valid || expected_effects.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        pc_model = 0;
        foreach (regs_model[i]) regs_model[i] = 0;
        foreach (dmem_model[i]) dmem_model[i] = 0;
        rst_n = 0;
        in_valid = 0;
        out_stall = 1;
        {instr_present, req_type, func_code, dest_reg, src_reg_a, src_reg_b, immediate} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // directed: a fixed sequence that exercises every opcode, divide by zero and an empty slot
        pending_instrs.push_back(mk(OP_LW, FN_ADD, 5'd1, 0, 0, 8'd255));
        pending_instrs.push_back(mk(OP_RTYPE, FN_DIV, 5'd0, 5'd1, 5'd0, 0));
        pending_instrs.push_back(mk(OP_BEQ, FN_ADD, 0, 5'd0, 5'd31, 8'd200));
        pending_instrs.push_back(mk(OP_RTYPE, FN_SUB, 5'd2, 5'd0, 5'd0, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_SUB, 5'd3, 5'd0, 5'd24, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_SUB, 5'd3, 5'd3, 5'd4, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_ADD, 5'd4, 5'd3, 5'd3, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_SUB, 5'd5, 5'd0, 5'd4, 0));
        pending_instrs.push_back(mk(OP_SW, FN_ADD, 5'd5, 0, 0, 8'd255));
        pending_instrs.push_back(mk(OP_LW, FN_ADD, 5'd31, 0, 0, 8'd255));
        pending_instrs.push_back(mk(OP_RTYPE, FN_MULT, 0, 5'd5, 5'd5, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_DIV, 0, 5'd31, 5'd5, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_DIV, 0, 5'd5, 5'd3, 0));
        pending_instrs.push_back(mk(OP_RTYPE, FN_DIV, 0, 5'd3, 5'd4, 0));
        pending_instrs.push_back(mk(OP_RTYPE, 3'd7, 0, 5'd3, 5'd4, 0));
        pending_instrs.push_back(mk(3'd7, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(3'd6, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(OP_BNE, 0, 0, 5'd3, 5'd4, 8'd255));
        pending_instrs.push_back(mk(OP_BEQ, 0, 0, 5'd3, 5'd3, 8'd254));
        pending_instrs.push_back(mk(OP_BNE, 0, 0, 5'd3, 5'd3, 8'd10));
        pending_instrs.push_back(mk(OP_J, 0, 0, 0, 0, 8'd0));
        pending_instrs.push_back(instr_t'(0));
        pending_instrs.push_back(mk(OP_SW, 0, 5'd31, 0, 0, 8'd0));
        drain();
        hold_send = 1;
        repeat (50) @(posedge clk);
        hold_send = 0;

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 11) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 73 : 11) : 0;
            repeat (220) pending_instrs.push_back(rand_instr());
            drain();
        end
        repeat (60) @(posedge clk);

        $display("ran %0d transactions: %0d divides, %0d zero divisors, %0d stores",
                 n_txn, n_div, n_dz, n_mem);
        if (errors == 0 && expected_effects.size() == 0)
            $display("mini_mips_execute_unit_core: match");
        else
            $display("mini_mips_execute_unit_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/mmeu_pkg.sv
hdl/mmeu_ctrl.sv
hdl/mmeu_dp.sv
hdl/mini_mips_execute_unit_core.sv
bench/tb_mini_mips_execute_unit_core.sv
